FILE: rtl/lselt_pkg.sv
// Shared types and constants of the lease lock table.
package lselt_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;

    localparam logic [2:0] OP_ACQUIRE = 3'd0;
    localparam logic [2:0] OP_RELEASE = 3'd1;
    localparam logic [2:0] OP_BLOCKED = 3'd2;
    localparam logic [2:0] OP_OWNER   = 3'd3;
    localparam logic [2:0] OP_COUNT   = 3'd4;
    localparam logic [2:0] OP_SWEEP   = 3'd5;

    localparam logic [1:0] ST_GRANTED = 2'd0;
    localparam logic [1:0] ST_SHARED  = 2'd1;
    localparam logic [1:0] ST_BLOCKED = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    localparam logic [31:0] ID_ONE = 32'd1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_WRITE = 5'b00100,
        S_PLACE = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

endpackage

FILE: rtl/leased_shared_exclusive_lock_table.sv
// Lease lock table: top level with sequencer and entry store.
//
//  channel | signals                                            | dir
//  in      | in_valid, in_stall, operation .. lease_length      | request in
//  out     | out_valid, out_stall, acquire_status .. live_total | result out
//
// One entry per cycle through a shared compare unit. Acquire takes two
// passes (expiry sweep, then match scan); other ops take one pass.
// An invalid acquire and unused codes go straight to the result.
// Reset clears all valid bits at once and next id to one. in_stall is high
// from accept until the result is taken; a stalled result holds.
module leased_shared_exclusive_lock_table #(
    parameter int TABLE_ENTRIES = lselt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    input  logic [2:0]  claim_kind,
    input  logic        hard_request,
    input  logic [31:0] claimant_id,
    input  logic [31:0] subject,
    input  logic [63:0] current_tick,
    input  logic [63:0] lease_length,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  acquire_status,
    output logic [31:0] lease_id,
    output logic        hit_flag,
    output logic [31:0] hard_owner,
    output logic [4:0]  live_total
);
    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] LAST = CW'(TABLE_ENTRIES - 1);

    lselt_pkg::state_t state_reg, state_next;

    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [31:0] id_mem   [TABLE_ENTRIES];
    logic [2:0]  kind_mem [TABLE_ENTRIES];
    logic        hard_mem [TABLE_ENTRIES];
    logic [31:0] own_mem  [TABLE_ENTRIES];
    logic [31:0] subj_mem [TABLE_ENTRIES];
    logic [63:0] exp_mem  [TABLE_ENTRIES];

    logic [2:0]  op_reg;
    logic [2:0]  kind_reg;
    logic        hreq_reg;
    logic [31:0] who_reg, subj_reg;
    logic [63:0] now_reg, exp_new_reg;
    logic [31:0] next_id_reg;

    logic [CW-1:0] idx_reg;
    logic          pass_reg;    // 0: sweep pass, 1: match pass (acquire)
    logic          shared_reg, found_reg, free_ok_reg;
    logic [IW-1:0] free_reg, hit_idx_reg;

    logic [1:0]  st_reg;
    logic [31:0] lid_reg, owner_reg;
    logic        hitf_reg;
    logic [4:0]  cnt_reg;

    // shared compare unit on the current entry
    logic [IW-1:0] ix;
    logic v, key, expd, live, own;
    assign ix   = idx_reg[IW-1:0];
    assign v    = valid_reg[ix];
    assign key  = kind_mem[ix] == kind_reg && subj_mem[ix] == subj_reg;
    assign expd = now_reg >= exp_mem[ix];
    assign live = v && !expd;
    assign own  = own_mem[ix] == who_reg;

    logic last;
    assign last = idx_reg == LAST;

    assign in_stall  = state_reg != lselt_pkg::S_IDLE;
    assign out_valid = state_reg == lselt_pkg::S_DONE;
    assign acquire_status = st_reg;
    assign lease_id   = lid_reg;
    assign hit_flag   = hitf_reg;
    assign hard_owner = owner_reg;
    assign live_total = cnt_reg;

    logic bad;
    assign bad = claim_kind == 3'd0 || claimant_id == 32'd0 || subject == 32'd0
                 || lease_length == 64'd0;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lselt_pkg::S_IDLE:
                if (in_valid)
                begin
                    if (operation == lselt_pkg::OP_ACQUIRE && bad)
                        state_next = lselt_pkg::S_DONE;
                    else if (operation inside {[3'd0:3'd5]})
                        state_next = lselt_pkg::S_SCAN;
                    else
                        state_next = lselt_pkg::S_DONE;
                end
            lselt_pkg::S_SCAN:
                if (op_reg == lselt_pkg::OP_ACQUIRE && pass_reg && v && key
                    && (own || hard_mem[ix] || hreq_reg))
                    state_next = own ? lselt_pkg::S_WRITE : lselt_pkg::S_DONE;
                else if (last)
                    state_next = (op_reg == lselt_pkg::OP_ACQUIRE && pass_reg)
                                 ? lselt_pkg::S_PLACE
                                 : ((op_reg == lselt_pkg::OP_ACQUIRE)
                                    ? lselt_pkg::S_SCAN : lselt_pkg::S_DONE);
            lselt_pkg::S_WRITE: state_next = lselt_pkg::S_DONE;
            lselt_pkg::S_PLACE: state_next = lselt_pkg::S_DONE;
            lselt_pkg::S_DONE:
                if (!out_stall)
                    state_next = lselt_pkg::S_IDLE;
            default: state_next = lselt_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= lselt_pkg::S_IDLE;
            valid_reg   <= '0;
            next_id_reg <= lselt_pkg::ID_ONE;
            idx_reg     <= '0;
            pass_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                lselt_pkg::S_IDLE:
                begin
                    idx_reg  <= '0;
                    pass_reg <= 1'b0;
                end
                lselt_pkg::S_SCAN:
                begin
                    idx_reg <= last ? '0 : idx_reg + 1'b1;
                    if (last)
                        pass_reg <= 1'b1;
                    if ((op_reg == lselt_pkg::OP_ACQUIRE && !pass_reg
                         || op_reg == lselt_pkg::OP_SWEEP) && v && expd)
                        valid_reg[ix] <= 1'b0;
                    if (op_reg == lselt_pkg::OP_RELEASE && v && key && own)
                        valid_reg[ix] <= 1'b0;
                end
                lselt_pkg::S_PLACE:
                    if (free_ok_reg)
                    begin
                        valid_reg[free_reg] <= 1'b1;
                        next_id_reg <= ((next_id_reg == 32'd0) ? lselt_pkg::ID_ONE
                                        : next_id_reg) + 32'd1;
                    end
                default: ;
            endcase
        end
    end

    // payload and entry fields
    always_ff @(posedge clk)
    begin
        case (state_reg)
            lselt_pkg::S_IDLE:
            begin
                op_reg      <= operation;
                kind_reg    <= claim_kind;
                hreq_reg    <= hard_request;
                who_reg     <= claimant_id;
                subj_reg    <= subject;
                now_reg     <= current_tick;
                exp_new_reg <= current_tick + lease_length;
                shared_reg  <= 1'b0;
                found_reg   <= 1'b0;
                free_ok_reg <= 1'b0;
                free_reg    <= '0;
                hit_idx_reg <= '0;
                st_reg      <= (operation == lselt_pkg::OP_ACQUIRE)
                               ? lselt_pkg::ST_INVALID : 2'd0;
                lid_reg     <= '0;
                owner_reg   <= '0;
                hitf_reg    <= 1'b0;
                cnt_reg     <= '0;
            end
            lselt_pkg::S_SCAN:
            begin
                case (op_reg)
                    lselt_pkg::OP_ACQUIRE:
                        if (pass_reg)
                        begin
                            if (!v && !free_ok_reg)
                            begin
                                free_ok_reg <= 1'b1;
                                free_reg    <= ix;
                            end
                            if (v && key)
                            begin
                                if (own)
                                begin
                                    hit_idx_reg <= ix;
                                    st_reg      <= lselt_pkg::ST_GRANTED;
                                    lid_reg     <= id_mem[ix];
                                end
                                else if (hard_mem[ix] || hreq_reg)
                                    st_reg <= lselt_pkg::ST_BLOCKED;
                                else
                                    shared_reg <= 1'b1;
                            end
                        end
                    lselt_pkg::OP_RELEASE:
                        if (v && key && own)
                            hitf_reg <= 1'b1;
                    lselt_pkg::OP_BLOCKED:
                        if (live && key && !own && hard_mem[ix])
                            hitf_reg <= 1'b1;
                    lselt_pkg::OP_OWNER:
                        if (live && key && hard_mem[ix] && !found_reg)
                        begin
                            found_reg <= 1'b1;
                            owner_reg <= own_mem[ix];
                        end
                    lselt_pkg::OP_COUNT:
                        if (live && cnt_reg != 5'd31)
                            cnt_reg <= cnt_reg + 5'd1;
                    default: ;
                endcase
            end
            lselt_pkg::S_WRITE:
            begin
                hard_mem[hit_idx_reg] <= hreq_reg;
                exp_mem[hit_idx_reg]  <= exp_new_reg;
            end
            lselt_pkg::S_PLACE:
                if (free_ok_reg)
                begin
                    id_mem[free_reg]   <= (next_id_reg == 32'd0) ? lselt_pkg::ID_ONE
                                          : next_id_reg;
                    kind_mem[free_reg] <= kind_reg;
                    hard_mem[free_reg] <= hreq_reg;
                    own_mem[free_reg]  <= who_reg;
                    subj_mem[free_reg] <= subj_reg;
                    exp_mem[free_reg]  <= exp_new_reg;
                    st_reg  <= shared_reg ? lselt_pkg::ST_SHARED : lselt_pkg::ST_GRANTED;
                    lid_reg <= (next_id_reg == 32'd0) ? lselt_pkg::ID_ONE : next_id_reg;
                end
                else
                    st_reg <= lselt_pkg::ST_BLOCKED;
            default: ;
        endcase
    end

    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("result shown while idle");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(acquire_status)
        && $stable(lease_id)) else $error("stalled result changed");
    a_id_nz: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && op_reg == lselt_pkg::OP_ACQUIRE
        && (acquire_status == lselt_pkg::ST_GRANTED
            || acquire_status == lselt_pkg::ST_SHARED) |-> lease_id != 32'd0)
        else $error("granted with zero id");
    a_idx: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lselt_pkg::S_SCAN |-> idx_reg <= LAST)
        else $error("scan index out of range");
endmodule
